@@ src/swd_pkg.sv @@
`timescale 1ns / 1ps

package swd_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;
	localparam int HOLD_BITS       = 16;
	localparam int THRESH_BITS     = 12;
	localparam int SLOPE_BITS      = 16;
	localparam int SLOPE_FRAC_BITS = 8;

	localparam logic [HOLD_BITS-1:0]          HOLD_MAX_RST  = 16'd100;
	localparam logic [HOLD_BITS-1:0]          HOLD_MIN_RST  = 16'd2;
	localparam logic [THRESH_BITS-1:0]        THRESH_RST    = 12'd30;
	localparam logic signed [SLOPE_BITS-1:0]  SLOPE_MIN_RST = -16'sd256;
	localparam logic signed [SLOPE_BITS-1:0]  SLOPE_MAX_RST = 16'sd256;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_HOLD_MAX  = 3'd0,
		REG_HOLD_MIN  = 3'd1,
		REG_THRESHOLD = 3'd2,
		REG_SLOPE_MIN = 3'd3,
		REG_SLOPE_MAX = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef struct packed {
		logic [HOLD_BITS-1:0]         hold_max;
		logic [HOLD_BITS-1:0]         hold_min;
		logic [THRESH_BITS-1:0]       threshold;
		logic signed [SLOPE_BITS-1:0] slope_min;
		logic signed [SLOPE_BITS-1:0] slope_max;
	} cfg_t;

	typedef struct packed {
		logic                 fire;
		logic [HOLD_BITS-1:0] hold_count;
	} release_t;

endpackage

@@ src/touch_swipe_direction_detector_unit.sv @@
// The sample that ends a gesture is held in the input register, then its swipe in the result register.
// Throughput: one sample per cycle, set by the single input register and result register.
// A sample is held back only while the result register is full and stalled.
// Reset: arst_n is asynchronous and active low; it clears the press state, the valid flags
// of both registers and restores the configuration defaults.
`timescale 1ns / 1ps

module touch_swipe_direction_detector_unit #(
	parameter int COORD_BITS = swd_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic                              touched,
	input  logic [COORD_BITS-1:0]             pos_x,
	input  logic [COORD_BITS-1:0]             pos_y,
	output logic                              swipe_valid,
	input  logic                              swipe_stall,
	output logic [1:0]                        direction,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [swd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import swd_pkg::*;

	cfg_t                      cfg;
	release_t                  rel;
	logic                      valid_s1;
	logic                      touched_s1;
	logic [COORD_BITS-1:0]     pos_x_s1;
	logic [COORD_BITS-1:0]     pos_y_s1;
	logic                      advance;
	logic                      step;
	logic                      emit;
	dir_t                      dir;
	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic                      out_valid_q;
	logic [1:0]                direction_q;

	assign cfg_ready    = 1'b1;
	assign advance      = !out_valid_q || !swipe_stall;
	assign step         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	swd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && !sample_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			touched_s1 <= touched;
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
		end
	end

	swd_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.touched  (touched_s1),
		.pos_x    (pos_x_s1),
		.pos_y    (pos_y_s1),
		.hold_max (cfg.hold_max),
		.rel      (rel),
		.dx       (dx),
		.dy       (dy)
	);

	swd_classifier #(.COORD_BITS(COORD_BITS)) u_classifier (
		.cfg  (cfg),
		.rel  (rel),
		.dx   (dx),
		.dy   (dy),
		.emit (emit),
		.dir  (dir)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			direction_q <= dir;
		end
	end

	assign swipe_valid = out_valid_q;
	assign direction   = direction_q;

endmodule

@@ src/swd_cfg_regs.sv @@
`timescale 1ns / 1ps

module swd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [swd_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [swd_pkg::CFG_DATA_BITS-1:0] wr_data,
	output swd_pkg::cfg_t                     cfg
);
	import swd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_max  <= HOLD_MAX_RST;
			cfg_q.hold_min  <= HOLD_MIN_RST;
			cfg_q.threshold <= THRESH_RST;
			cfg_q.slope_min <= SLOPE_MIN_RST;
			cfg_q.slope_max <= SLOPE_MAX_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_HOLD_MAX:  cfg_q.hold_max  <= wr_data[HOLD_BITS-1:0];
				REG_HOLD_MIN:  cfg_q.hold_min  <= wr_data[HOLD_BITS-1:0];
				REG_THRESHOLD: cfg_q.threshold <= wr_data[THRESH_BITS-1:0];
				REG_SLOPE_MIN: cfg_q.slope_min <= wr_data[SLOPE_BITS-1:0];
				REG_SLOPE_MAX: cfg_q.slope_max <= wr_data[SLOPE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/swd_tracker.sv @@
`timescale 1ns / 1ps

module swd_tracker #(
	parameter int COORD_BITS = swd_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          touched,
	input  logic [COORD_BITS-1:0]         pos_x,
	input  logic [COORD_BITS-1:0]         pos_y,
	input  logic [swd_pkg::HOLD_BITS-1:0] hold_max,
	output swd_pkg::release_t             rel,
	output logic signed [COORD_BITS:0]    dx,
	output logic signed [COORD_BITS:0]    dy
);
	import swd_pkg::*;

	logic                  press_active_q;
	logic [HOLD_BITS-1:0]  hold_count_q;
	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [COORD_BITS-1:0] recent_x_q;
	logic [COORD_BITS-1:0] recent_y_q;
	logic                  below_max;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	assign below_max = hold_count_q < hold_max;

	// A held touch that has reached the maximum ends on the current position;
	// a lifted touch ends on the last pressed position.
	always_comb begin
		rel.hold_count = hold_count_q;
		rel.fire       = 1'b0;
		end_x          = recent_x_q;
		end_y          = recent_y_q;
		if (touched) begin
			end_x = pos_x;
			end_y = pos_y;
			if (press_active_q && !below_max) begin
				rel.fire = 1'b1;
			end
		end else if (press_active_q) begin
			rel.fire = 1'b1;
		end
	end

	assign dx = $signed({1'b0, end_x}) - $signed({1'b0, start_x_q});
	assign dy = $signed({1'b0, end_y}) - $signed({1'b0, start_y_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_active_q <= 1'b0;
			hold_count_q   <= '0;
			start_x_q      <= '0;
			start_y_q      <= '0;
			recent_x_q     <= '0;
			recent_y_q     <= '0;
		end else if (step) begin
			if (touched) begin
				recent_x_q <= pos_x;
				recent_y_q <= pos_y;
				if (!press_active_q) begin
					press_active_q <= 1'b1;
					hold_count_q   <= '0;
					start_x_q      <= pos_x;
					start_y_q      <= pos_y;
				end else if (below_max) begin
					hold_count_q <= hold_count_q + 1'b1;
				end else begin
					press_active_q <= 1'b0;
				end
			end else begin
				press_active_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/swd_classifier.sv @@
`timescale 1ns / 1ps

module swd_classifier #(
	parameter int COORD_BITS = swd_pkg::COORD_BITS_DEF
) (
	input  swd_pkg::cfg_t              cfg,
	input  swd_pkg::release_t          rel,
	input  logic signed [COORD_BITS:0] dx,
	input  logic signed [COORD_BITS:0] dy,
	output logic                       emit,
	output swd_pkg::dir_t              dir
);
	import swd_pkg::*;

	localparam int DW   = COORD_BITS + 1;
	localparam int PW   = SLOPE_BITS + DW;
	localparam int PAD  = PW - DW - SLOPE_FRAC_BITS;
	localparam int CMPW = (DW > THRESH_BITS) ? DW : THRESH_BITS;

	logic [DW-1:0]          abs_dx;
	logic [DW-1:0]          abs_dy;
	logic                   small_move;
	logic                   long_hold;
	logic                   dx_zero;
	logic                   dy_zero;
	logic signed [PW-1:0]   lhs;
	logic signed [PW-1:0]   lo;
	logic signed [PW-1:0]   hi;
	logic                   below;
	logic                   above;

	assign abs_dx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign abs_dy = dy[DW-1] ? DW'(-dy) : DW'(dy);

	assign small_move = (CMPW'(abs_dx) < CMPW'(cfg.threshold)) &&
			(CMPW'(abs_dy) < CMPW'(cfg.threshold));
	assign long_hold  = !(rel.hold_count < cfg.hold_min);
	assign dx_zero    = dx == '0;
	assign dy_zero    = dy == '0;

	assign lhs = {{PAD{dy[DW-1]}}, dy, {SLOPE_FRAC_BITS{1'b0}}};
	assign lo  = PW'(cfg.slope_min) * PW'(dx);
	assign hi  = PW'(cfg.slope_max) * PW'(dx);

	// For a negative dx the sense of both comparisons flips.
	assign below = dx[DW-1] ? (lhs > lo) : (lhs < lo);
	assign above = dx[DW-1] ? (lhs < hi) : (lhs > hi);

	assign emit = rel.fire && long_hold && !small_move && !(dx_zero && dy_zero);

	always_comb begin
		if (dx_zero || below || above) begin
			dir = dy[DW-1] ? DIR_UP : DIR_DOWN;
		end else begin
			dir = dx[DW-1] ? DIR_LEFT : DIR_RIGHT;
		end
	end

endmodule

@@ src/swd_checker.sv @@
`timescale 1ns / 1ps

module swd_checker #(
	parameter int COORD_BITS = swd_pkg::COORD_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              sample_valid,
	input logic                              sample_stall,
	input logic                              touched,
	input logic [COORD_BITS-1:0]             pos_x,
	input logic [COORD_BITS-1:0]             pos_y,
	input logic                              swipe_valid,
	input logic                              swipe_stall,
	input logic [1:0]                        direction,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [swd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input logic [swd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	// Samples are only held back while a finished swipe waits downstream.
	a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (swipe_valid && swipe_stall))
		else $error("sample stall without a stalled swipe");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

	a_swipe_held: assert property (@(posedge clk) disable iff (!arst_n)
		(swipe_valid && swipe_stall) |=> swipe_valid)
		else $error("stalled swipe withdrawn");

	a_direction_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(swipe_valid && swipe_stall) |=> $stable(direction))
		else $error("stalled swipe direction changed");

endmodule

bind touch_swipe_direction_detector_unit swd_checker #(.COORD_BITS(COORD_BITS)) u_swd_checker (.*);
